@@ rtl/core/rbgma_pkg.sv @@
// Package for the RBG mask allocator: widths, types and bit-level helper functions.
`default_nettype none
package rbgma_pkg;

  localparam int GROUPS = 32;
  localparam int CNT_W  = 6;
  localparam int IDX_W  = 5;
  localparam int LEVELS = 5;

  localparam logic [CNT_W-1:0] MASK_SIZE_RESET = 6'd25;

  typedef logic [GROUPS-1:0] grp_mask_t;
  typedef logic [CNT_W-1:0]  grp_cnt_t;
  typedef logic [IDX_W-1:0]  grp_idx_t;

  function automatic grp_cnt_t popcnt(grp_mask_t v);
    grp_cnt_t s [GROUPS];
    for (int i = 0; i < GROUPS; i++) begin
      s[i] = {{(CNT_W-1){1'b0}}, v[i]};
    end
    for (int l = 0; l < LEVELS; l++) begin
      for (int k = 0; k < (GROUPS >> (l + 1)); k++) begin
        s[k] = s[2*k] + s[2*k+1];
      end
    end
    return s[0];
  endfunction

  function automatic grp_cnt_t run_len(grp_mask_t v, int unsigned start);
    logic [GROUPS:0] x;
    logic [GROUPS:0] low;
    grp_cnt_t        n;
    x   = {1'b1, ~(v >> start)};
    low = x & (~x + {{GROUPS{1'b0}}, 1'b1});
    n   = '0;
    for (int b = 0; b <= GROUPS; b++) begin
      if (low[b]) begin
        n = n | CNT_W'(b);
      end
    end
    return n;
  endfunction

  function automatic grp_mask_t range_mask(grp_idx_t start, grp_cnt_t len);
    logic [CNT_W:0] lo;
    logic [CNT_W:0] hi;
    grp_mask_t      m;
    lo = {2'b00, start};
    hi = {2'b00, start} + {1'b0, len};
    for (int j = 0; j < GROUPS; j++) begin
      m[j] = ((CNT_W+1)'(j) >= lo) && ((CNT_W+1)'(j) < hi);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/rbg_mask_allocator.sv @@
// Top level of the RBG mask allocator: input register, single-pass allocation, result register.
`default_nettype none
// Accepts one request per cycle unless out_ready stalls the output; each request passes
// through the input register and its result through the result register, one result per cycle
// sustained. The rate is set by the single pass of run-length, first-fit, longest-run and
// prefix-count logic between the input register and the result register. The mask size
// register is used during the allocation pass; write it only while the block is idle.
module rbg_mask_allocator
  import rbgma_pkg::*;
#(
  parameter int MAX_GROUPS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [5:0]  cfg_mask_size,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_used_mask,
  input  wire logic [5:0]  in_want_size,
  input  wire logic        in_contiguous,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_alloc_mask,
  output logic [5:0]       out_alloc_count
);

  localparam grp_cnt_t SIZE_LIMIT = CNT_W'((MAX_GROUPS < GROUPS) ? MAX_GROUPS : GROUPS);

  grp_cnt_t  mask_size_r;
  logic      s1_valid_r;
  grp_mask_t used_r;
  grp_cnt_t  want_r;
  logic      contig_r;
  logic      out_valid_r;
  grp_mask_t alloc_mask_r;
  grp_cnt_t  alloc_count_r;

  logic      s1_adv;
  grp_cnt_t  eff_size;
  grp_mask_t size_mask;
  grp_mask_t free_bits;
  grp_cnt_t  len [GROUPS];
  grp_mask_t fit;
  grp_mask_t fit_low;
  grp_idx_t  fit_idx;
  logic      fit_found;
  grp_cnt_t  tl [LEVELS+1][GROUPS];
  grp_idx_t  ti [LEVELS+1][GROUPS];
  grp_cnt_t  best_len;
  grp_idx_t  best_idx;
  grp_mask_t scat_mask;
  grp_cnt_t  free_cnt;
  grp_mask_t alloc_mask_nxt;
  grp_cnt_t  alloc_count_nxt;

  assign cfg_ready       = 1'b1;
  assign s1_adv          = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready        = !s1_valid_r || s1_adv;
  assign out_valid       = out_valid_r;
  assign out_alloc_mask  = alloc_mask_r;
  assign out_alloc_count = alloc_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_size_r <= MASK_SIZE_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mask_size_r <= cfg_mask_size;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      used_r   <= in_used_mask;
      want_r   <= in_want_size;
      contig_r <= in_contiguous;
    end
    if (s1_adv) begin
      alloc_mask_r  <= alloc_mask_nxt;
      alloc_count_r <= alloc_count_nxt;
    end
  end

  always_comb begin
    eff_size = (mask_size_r > SIZE_LIMIT) ? SIZE_LIMIT : mask_size_r;
    for (int i = 0; i < GROUPS; i++) begin
      size_mask[i] = CNT_W'(i) < eff_size;
    end
    free_bits = ~used_r & size_mask;

    for (int i = 0; i < GROUPS; i++) begin
      len[i] = run_len(free_bits, i);
      fit[i] = (want_r != '0) && (len[i] >= want_r);
    end

    fit_found = |fit;
    fit_low   = fit & (~fit + {{(GROUPS-1){1'b0}}, 1'b1});
    fit_idx   = '0;
    for (int i = 0; i < GROUPS; i++) begin
      if (fit_low[i]) begin
        fit_idx = fit_idx | IDX_W'(i);
      end
    end

    for (int l = 0; l <= LEVELS; l++) begin
      for (int k = 0; k < GROUPS; k++) begin
        tl[l][k] = '0;
        ti[l][k] = '0;
      end
    end
    for (int i = 0; i < GROUPS; i++) begin
      tl[0][i] = len[i];
      ti[0][i] = IDX_W'(i);
    end
    for (int l = 0; l < LEVELS; l++) begin
      for (int k = 0; k < (GROUPS >> (l + 1)); k++) begin
        if (tl[l][2*k+1] > tl[l][2*k]) begin
          tl[l+1][k] = tl[l][2*k+1];
          ti[l+1][k] = ti[l][2*k+1];
        end else begin
          tl[l+1][k] = tl[l][2*k];
          ti[l+1][k] = ti[l][2*k];
        end
      end
    end
    best_len = tl[LEVELS][0];
    best_idx = ti[LEVELS][0];

    for (int i = 0; i < GROUPS; i++) begin
      scat_mask[i] = free_bits[i] && (popcnt(free_bits & grp_mask_t'((64'd1 << i) - 64'd1))
                     < want_r);
    end
    free_cnt = popcnt(free_bits);

    if (contig_r) begin
      if (want_r == '0) begin
        alloc_mask_nxt  = '0;
        alloc_count_nxt = '0;
      end else if (fit_found) begin
        alloc_mask_nxt  = range_mask(fit_idx, want_r);
        alloc_count_nxt = want_r;
      end else begin
        alloc_mask_nxt  = range_mask(best_idx, best_len);
        alloc_count_nxt = best_len;
      end
    end else begin
      alloc_mask_nxt  = scat_mask;
      alloc_count_nxt = (want_r < free_cnt) ? want_r : free_cnt;
    end
  end

endmodule
`default_nettype wire

@@ tb/tb_rbg_mask_allocator.sv @@
// Self-checking testbench for the RBG mask allocator: random and directed requests with scoreboard.
`timescale 1ns / 1ps
module tb_rbg_mask_allocator
  import rbgma_pkg::*;
();

  localparam int MAX_GROUPS  = 32;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 65;

  typedef struct packed {
    grp_mask_t mask;
    grp_cnt_t  count;
  } grant_t;

  class alloc_scoreboard;
    logic [5:0] mask_size;
    grant_t     expected_grants[$];
    int         failures;

    function new();
      mask_size = MASK_SIZE_RESET;
      failures  = 0;
    endfunction

    function void set_mask_size(logic [5:0] v);
      mask_size = v;
    endfunction

    function int pending();
      return expected_grants.size();
    endfunction

    function int ones(grp_mask_t v);
      int c;
      c = 0;
      for (int i = 0; i < GROUPS; i++) c += v[i];
      return c;
    endfunction

    function grp_mask_t span(int lo, int len);
      grp_mask_t m;
      m = '0;
      for (int i = lo; i < lo + len && i < GROUPS; i++) m[i] = 1'b1;
      return m;
    endfunction

    function grp_mask_t predict_grant(grp_mask_t used, grp_cnt_t want, logic contig);
      int        size;
      int        w;
      int        n;
      int        pos;
      int        stop;
      int        max_pos;
      int        best_start;
      int        best_len;
      int        taken;
      grp_mask_t avail;
      grp_mask_t grant;
      size = (mask_size > MAX_GROUPS) ? MAX_GROUPS : mask_size;
      if (size > GROUPS) size = GROUPS;
      avail = '0;
      for (int i = 0; i < size; i++) avail[i] = ~used[i];
      w = want;
      grant = '0;
      if (contig) begin
        if (w == 0) return '0;
        n = 0;
        best_start = 0;
        best_len = 0;
        while (n < size) begin
          pos = n;
          while (pos < size && !avail[pos]) pos++;
          if (pos >= size) break;
          max_pos = pos + w;
          if (max_pos > size) max_pos = size;
          stop = pos + 1;
          while (stop < max_pos && avail[stop]) stop++;
          if (stop - pos >= w) return span(pos, stop - pos);
          if (stop - pos > best_len) begin
            best_start = pos;
            best_len = stop - pos;
          end
          n = stop;
        end
        return span(best_start, best_len);
      end
      if (w >= size || w >= ones(avail)) return avail;
      taken = 0;
      for (int i = 0; i < size; i++) begin
        if (avail[i] && taken < w) begin
          grant[i] = 1'b1;
          taken++;
        end
      end
      return grant;
    endfunction

    function void note_request(grp_mask_t used, grp_cnt_t want, logic contig);
      grant_t g;
      g.mask  = predict_grant(used, want, contig);
      g.count = grp_cnt_t'(ones(g.mask));
      expected_grants.push_back(g);
    endfunction

    function void check_result(grp_mask_t mask, grp_cnt_t count);
      grant_t g;
      if (expected_grants.size() == 0) begin
        $error("unexpected result: alloc_mask %h alloc_count %0d", mask, count);
        failures++;
        return;
      end
      g = expected_grants.pop_front();
      if (mask !== g.mask) begin
        $error("alloc_mask: expected %h, actual %h", g.mask, mask);
        failures++;
      end
      if (count !== g.count) begin
        $error("alloc_count: expected %0d, actual %0d", g.count, count);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [5:0]  cfg_mask_size = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_used_mask = '0;
  logic [5:0]  in_want_size = '0;
  logic        in_contiguous = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_alloc_mask;
  logic [5:0]  out_alloc_count;

  alloc_scoreboard sb = new();
  int burst_left = 0;
  int cycle_count = 0;
  int rx_cycle = 0;
  int stall_mode = 0;

  rbg_mask_allocator #(
    .MAX_GROUPS(MAX_GROUPS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_mask_size  (cfg_mask_size),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_used_mask   (in_used_mask),
    .in_want_size   (in_want_size),
    .in_contiguous  (in_contiguous),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_alloc_mask (out_alloc_mask),
    .out_alloc_count(out_alloc_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** rbg_mask_allocator: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_request(in_used_mask, in_want_size, in_contiguous);
    if (rst_n && out_valid && out_ready) sb.check_result(out_alloc_mask, out_alloc_count);
  end

  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 50 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready = 1'b1;
      1: out_ready = ($urandom_range(0, 3) != 0);
      2: out_ready = ((rx_cycle % 6) < 2);
      default: out_ready = ($urandom_range(0, 1) == 1);
    endcase
  end

  function automatic grp_mask_t random_used();
    grp_mask_t m;
    int        p;
    int        len;
    m = '0;
    case ($urandom_range(0, 5))
      0: m = $urandom();
      1: m = $urandom() & $urandom() & $urandom();
      2: m = $urandom() | $urandom();
      3: m = '0;
      4: begin
        m = '1;
        p = $urandom_range(0, 31);
        len = $urandom_range(1, 12);
        for (int i = p; i < p + len && i < GROUPS; i++) m[i] = 1'b0;
      end
      default: begin
        p = 0;
        while (p < GROUPS) begin
          len = $urandom_range(1, 8);
          if ($urandom_range(0, 1) == 1) begin
            for (int i = p; i < p + len && i < GROUPS; i++) m[i] = 1'b1;
          end
          p += len;
        end
      end
    endcase
    return m;
  endfunction

  task automatic send_request(input grp_mask_t used, input int want, input logic contig);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_used_mask  = used;
    in_want_size  = want[5:0];
    in_contiguous = contig;
    in_valid      = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_mask_size(input logic [5:0] v);
    cfg_mask_size = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_mask_size(v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_phase(input int items);
    int want;
    for (int k = 0; k < items; k++) begin
      want = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32) : $urandom_range(0, 12);
      send_request(random_used(), want, ($urandom_range(0, 1) == 1));
    end
  endtask

  initial begin
    logic [5:0] sizes[$];
    sizes = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd33, 6'd2, 6'd16, 6'd31};
    repeat (3) sizes.push_back(6'($urandom_range(0, 63)));
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_request(32'h0000_0000, 0, 1'b1);
    send_request(32'h0000_0000, 0, 1'b0);
    send_request(32'h0000_0000, 32, 1'b1);
    send_request(32'h0000_0000, 32, 1'b0);
    send_request(32'hFFFF_FFFF, 5, 1'b1);
    send_request(32'hFFFF_FFFF, 5, 1'b0);
    send_request(32'h01FF_FFFF, 7, 1'b1);
    send_request(32'h01FF_FFFF, 7, 1'b0);
    send_request(32'hAAAA_AAAA, 3, 1'b1);
    send_request(32'h5555_5555, 3, 1'b0);
    send_request(32'hFFFF_FC04, 4, 1'b1);
    send_request(~32'h0000_0077, 5, 1'b1);
    send_request(~32'h0000_007B, 8, 1'b1);
    send_request(32'h0000_0000, 1, 1'b1);
    send_request(32'h0000_0001, 1, 1'b0);
    send_request(32'h0000_0000, 24, 1'b1);
    send_request(32'h0000_0000, 25, 1'b0);
    send_request(32'hFFFF_0000, 16, 1'b0);
    send_request(32'hFFFF_0000, 15, 1'b0);
    send_request(32'h00FF_FFFF, 2, 1'b1);
    send_request(32'h8000_0000, 32, 1'b1);
    random_phase(PHASE_ITEMS);

    foreach (sizes[s]) begin
      drain();
      write_mask_size(sizes[s]);
      if (sizes[s] == 6'd32) begin
        send_request(32'h0000_0000, 32, 1'b1);
        send_request(32'h7FFF_FFFF, 1, 1'b1);
        send_request(32'h0000_0000, 31, 1'b0);
      end
      random_phase(PHASE_ITEMS);
    end

    drain();
    if (sb.failures == 0) begin
      $display("** rbg_mask_allocator: PASSED **");
    end else begin
      $display("** rbg_mask_allocator: FAILED **");
    end
    $finish;
  end

endmodule
